// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the Moran's I engine.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is low.
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Checks that a condition implies another condition in the next clock cycle.
`define ASSERT_NEXT(label, cond, expr) \
   `ASSERT_CLK(label, (cond) |=> (expr))

`endif

// ===== sv/mi_pkg.sv =====
// Package for the Moran's I engine: sizes, codes, states and control structs.
// Depends on nothing; mi_mac, mi_div and moran_i_statistic import it.
package mi_pkg;

   localparam int MAX_OBS = 64;
   localparam int OBS_AW  = $clog2(MAX_OBS);
   localparam int WGT_AW  = 2 * OBS_AW;
   localparam int IDX_W   = OBS_AW + 1;
   localparam int CNT_W   = 7;

   localparam int OP_W    = 25;
   localparam int PROD_W  = 2 * OP_W;
   localparam int ACC_W   = 100;
   localparam int ZP_W    = 23;
   localparam int SUMW_W  = 28;
   localparam int SZ2_W   = 52;
   localparam int DEN_W   = 81;
   localparam int DIVR_W  = DEN_W + 1;
   localparam int NUM_W   = 100;
   localparam int DCNT_W  = $clog2(NUM_W + 1);

   localparam logic [1:0] CMD_LOAD_OBS = 2'd0;
   localparam logic [1:0] CMD_LOAD_WGT = 2'd1;
   localparam logic [1:0] CMD_COMPUTE  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUMY,
      S_ZP,
      S_SUMZ2,
      S_ROWZ,
      S_ROWZD,
      S_ROWW,
      S_TERM,
      S_DEN,
      S_NUM,
      S_DIV,
      S_OUT
   } seq_state_type;

   // One operation for the shared multiply-accumulate unit.
   typedef struct packed {
      logic       valid;
      logic       acc_en;
      logic       dest;
      logic       clear;
      logic [1:0] shift;
   } mac_op_type;

   // Issue slot: a memory read was started for this loop index.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } iss_type;

endpackage

// ===== sv/mi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/mi_mac.sv =====
// Shared signed 25x25 multiplier with two wide accumulators.
// Depends on mi_pkg. The product is registered before the accumulate stage.
module mi_mac
   import mi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_op_type               op,
   input  logic signed [OP_W-1:0]   op_a,
   input  logic signed [OP_W-1:0]   op_b,
   output logic signed [PROD_W-1:0] prod,
   output logic signed [ACC_W-1:0]  acc0,
   output logic signed [ACC_W-1:0]  acc1,
   output logic                     busy
);

   mac_op_type               pop_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc0_ff;
   logic signed [ACC_W-1:0]  acc1_ff;
   logic signed [PROD_W-1:0] mul_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  sum_in;

   assign mul_in   = op_a * op_b;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (pop_ff.shift)
         2'd0:    addend = prod_ext;
         2'd1:    addend = prod_ext <<< 24;
         2'd2:    addend = prod_ext <<< 48;
         default: addend = prod_ext <<< 72;
      endcase
      if (pop_ff.clear) begin
         base = '0;
      end else if (pop_ff.dest) begin
         base = acc1_ff;
      end else begin
         base = acc0_ff;
      end
      sum_in = base + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff <= '0;
      end else begin
         pop_ff <= op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_in;
      if (pop_ff.valid && pop_ff.acc_en) begin
         if (pop_ff.dest) begin
            acc1_ff <= sum_in;
         end else begin
            acc0_ff <= sum_in;
         end
      end
   end

   assign prod = prod_ff;
   assign acc0 = acc0_ff;
   assign acc1 = acc1_ff;
   assign busy = pop_ff.valid;

endmodule

// ===== sv/mi_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mi_pkg for the operand widths.
module mi_div
   import mi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DIVR_W-1:0] den,
   output logic              busy,
   output logic              done,
   output logic [NUM_W-1:0]  quo
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] den_ff, den_in;
   logic [DIVR_W:0]   rem_sh;
   logic [DIVR_W+1:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, q_ff[NUM_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // The quotient bit shifts in where the numerator bit left.
         if (!diff[DIVR_W+1]) begin
            rem_in = diff[DIVR_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVR_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// ===== sv/moran_i_statistic.sv =====
// Moran's I engine: sequencer, observation/weight/deviation memories, output register.
// Depends on mi_pkg, mi_ram, mi_mac, mi_div and assert_macros.svh.
//
// Load words (observation, weight) are taken one per cycle while the block
// is idle. A compute word makes the block busy, n being the observation
// count: every product of the statistic goes through the one shared 25x25
// multiply-accumulate unit, an n-entry pass each for the mean, the
// deviations and their squares, a pass over each weight row, and a 100-bit
// bit-serial division at the end. The result word waits in an output
// register; loads are taken again while it waits.
module moran_i_statistic
   import mi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,     // obs_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // row[5:0], col[11:6], value[28:12], zero pad
   input  logic [1:0]  req_tuser,     // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // statistic[31:0]
   output logic [1:0]  rsp_tuser      // status
);

   `include "assert_macros.svh"

   seq_state_type     state_ff, state_in;
   logic [6:0]        obs_count_ff;
   logic [IDX_W-1:0]  n_ff, n_in, n_eff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  lim;
   iss_type           iss_ff, iss_in;
   iss_type           zp_tag_ff, zp_tag_in;
   logic [ZP_W-1:0]   sum_y_ff, sum_y_in;
   logic [SZ2_W-1:0]  sum_z2_ff, sum_z2_in;
   logic [SUMW_W-1:0] sum_w_ff, sum_w_in;
   logic [ZP_W-1:0]   zi_ff, zi_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [31:0]       res_stat_ff, res_stat_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;
   logic [1:0]        rsp_user_ff;
   logic              rsp_load;

   logic              req_accept;
   logic [5:0]        req_row, req_col;
   logic [16:0]       req_value;
   logic [15:0]       obs_sat, wgt_sat;
   logic              stream_state, pipe_idle, issue, stream_done;

   logic              obs_we;
   logic [OBS_AW-1:0] obs_raddr;
   logic [15:0]       obs_rdata;
   logic              wgt_we;
   logic [15:0]       wgt_rdata;
   logic              zp_we;
   logic [OBS_AW-1:0] zp_raddr;
   logic [ZP_W-1:0]   zp_wdata, zp_rdata;

   mac_op_type               mac_op;
   logic signed [OP_W-1:0]   mac_a, mac_b;
   logic signed [PROD_W-1:0] mac_prod;
   logic signed [ACC_W-1:0]  acc0, acc1;
   logic [ACC_W-1:0]         mag;
   logic [23:0]              mag_dig, wdig, zdig;
   logic [2:0]               den_shift;
   logic                     mac_busy;

   logic             div_start, div_busy, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic             neg;
   logic [31:0]      limit;

   assign req_row    = req_tdata[5:0];
   assign req_col    = req_tdata[11:6];
   assign req_value  = req_tdata[28:12];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (!req_value[16] && req_value[15]) begin
         obs_sat = 16'h7FFF;
      end else if (req_value[16] && !req_value[15]) begin
         obs_sat = 16'h8000;
      end else begin
         obs_sat = req_value[15:0];
      end
      wgt_sat = req_value[16] ? 16'h0000 : req_value[15:0];
   end

   assign n_eff = (obs_count_ff > 7'(MAX_OBS)) ? IDX_W'(MAX_OBS) : IDX_W'(obs_count_ff);
   assign obs_we = req_accept && (req_tuser == CMD_LOAD_OBS);
   assign wgt_we = req_accept && (req_tuser == CMD_LOAD_WGT);

   // Deviation written from the registered product, at the index held in zp_tag_ff.
   assign zp_we    = zp_tag_ff.valid;
   assign zp_wdata = mac_prod[ZP_W-1:0] - sum_y_ff;

   assign obs_raddr = idx_ff[OBS_AW-1:0];
   assign zp_raddr  = (state_ff == S_ROWZ) ? row_ff[OBS_AW-1:0] : idx_ff[OBS_AW-1:0];

   mi_ram #(.WIDTH(16), .DEPTH(MAX_OBS)) u_obs_ram (
      .clock (clock),
      .we    (obs_we),
      .waddr (req_row[OBS_AW-1:0]),
      .wdata (obs_sat),
      .raddr (obs_raddr),
      .rdata (obs_rdata)
   );

   mi_ram #(.WIDTH(16), .DEPTH(MAX_OBS * MAX_OBS)) u_wgt_ram (
      .clock (clock),
      .we    (wgt_we),
      .waddr ({req_row[OBS_AW-1:0], req_col[OBS_AW-1:0]}),
      .wdata (wgt_sat),
      .raddr ({row_ff[OBS_AW-1:0], idx_ff[OBS_AW-1:0]}),
      .rdata (wgt_rdata)
   );

   mi_ram #(.WIDTH(ZP_W), .DEPTH(MAX_OBS)) u_zp_ram (
      .clock (clock),
      .we    (zp_we),
      .waddr (zp_tag_ff.idx[OBS_AW-1:0]),
      .wdata (zp_wdata),
      .raddr (zp_raddr),
      .rdata (zp_rdata)
   );

   mi_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .prod  (mac_prod),
      .acc0  (acc0),
      .acc1  (acc1),
      .busy  (mac_busy)
   );

   assign div_num = {acc1[NUM_W-18:0], 17'b0} + {{(NUM_W-DEN_W){1'b0}}, den_ff};

   mi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ({den_ff, 1'b0}),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Loop bound of each pass through the shared unit.
   always_comb begin
      stream_state = 1'b1;
      unique case (state_ff)
         S_SUMY, S_ZP, S_SUMZ2, S_ROWW: lim = n_ff;
         S_TERM:  lim = IDX_W'(2);
         S_DEN:   lim = IDX_W'(8);
         S_NUM:   lim = IDX_W'(4);
         default: begin
            lim          = '0;
            stream_state = 1'b0;
         end
      endcase
   end

   assign pipe_idle   = !iss_ff.valid && !mac_busy;
   assign issue       = stream_state && (idx_ff < lim);
   assign stream_done = stream_state && (idx_ff == lim) && pipe_idle;

   assign neg   = acc0[ACC_W-1];
   assign mag   = neg ? -acc0 : acc0;
   assign limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

   always_comb begin
      case (iss_ff.idx[1:0])
         2'd0:    mag_dig = mag[23:0];
         2'd1:    mag_dig = mag[47:24];
         2'd2:    mag_dig = mag[71:48];
         default: mag_dig = mag[95:72];
      endcase
      wdig = iss_ff.idx[2] ? {20'b0, sum_w_ff[27:24]} : sum_w_ff[23:0];
      case (iss_ff.idx[1:0])
         2'd0:    zdig = sum_z2_ff[23:0];
         2'd1:    zdig = sum_z2_ff[47:24];
         2'd2:    zdig = {20'b0, sum_z2_ff[51:48]};
         default: zdig = '0;
      endcase
      den_shift = {2'b0, iss_ff.idx[2]} + {1'b0, iss_ff.idx[1:0]};
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      row_in        = row_ff;
      sum_y_in      = sum_y_ff;
      sum_z2_in     = sum_z2_ff;
      sum_w_in      = sum_w_ff;
      zi_in         = zi_ff;
      den_in        = den_ff;
      res_stat_in   = res_stat_ff;
      res_status_in = res_status_ff;
      iss_in        = '0;
      zp_tag_in     = '0;
      mac_op        = '0;
      mac_a         = '0;
      mac_b         = '0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;

      if (issue) begin
         iss_in.valid = 1'b1;
         iss_in.idx   = idx_ff;
         idx_in       = idx_ff + 1'b1;
      end

      // Second stage of every pass: feed the unit, with memory data in the passes that read it.
      if (iss_ff.valid) begin
         mac_op.valid  = 1'b1;
         mac_op.acc_en = 1'b1;
         mac_op.dest   = 1'b1;
         mac_op.clear  = (iss_ff.idx == '0);
         unique case (state_ff)
            S_SUMY: begin
               mac_a = OP_W'(signed'(obs_rdata));
               mac_b = OP_W'(1);
            end
            S_ZP: begin
               mac_op.acc_en = 1'b0;
               mac_a         = OP_W'(signed'(obs_rdata));
               mac_b         = signed'({{(OP_W-IDX_W){1'b0}}, n_ff});
               zp_tag_in     = iss_ff;
            end
            S_SUMZ2: begin
               mac_a = OP_W'(signed'(zp_rdata));
               mac_b = OP_W'(signed'(zp_rdata));
            end
            S_ROWW: begin
               mac_a    = signed'({{(OP_W-16){1'b0}}, wgt_rdata});
               mac_b    = OP_W'(signed'(zp_rdata));
               sum_w_in = sum_w_ff + SUMW_W'(wgt_rdata);
            end
            S_TERM: begin
               // Row sum split into a low unsigned and a high signed digit.
               mac_op.dest  = 1'b0;
               mac_op.clear = (row_ff == '0) && (iss_ff.idx == '0);
               mac_op.shift = {1'b0, iss_ff.idx[0]};
               mac_a        = OP_W'(signed'(zi_ff));
               mac_b        = iss_ff.idx[0] ? acc1[48:24] : signed'({1'b0, acc1[23:0]});
            end
            S_DEN: begin
               mac_op.shift = den_shift[1:0];
               mac_a        = signed'({1'b0, wdig});
               mac_b        = signed'({1'b0, zdig});
            end
            S_NUM: begin
               mac_op.shift = iss_ff.idx[1:0];
               mac_a        = signed'({1'b0, mag_dig});
               mac_b        = signed'({{(OP_W-IDX_W){1'b0}}, n_ff});
            end
            default: begin
               mac_op = '0;
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == CMD_COMPUTE)) begin
               n_in     = n_eff;
               idx_in   = '0;
               row_in   = '0;
               sum_w_in = '0;
               if (n_eff == '0) begin
                  res_stat_in   = '0;
                  res_status_in = ST_ZERO_DEN;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_SUMY;
               end
            end
         end
         S_SUMY: begin
            if (stream_done) begin
               sum_y_in = acc1[ZP_W-1:0];
               idx_in   = '0;
               state_in = S_ZP;
            end
         end
         S_ZP: begin
            if (stream_done) begin
               idx_in   = '0;
               state_in = S_SUMZ2;
            end
         end
         S_SUMZ2: begin
            if (stream_done) begin
               sum_z2_in = acc1[SZ2_W-1:0];
               row_in    = '0;
               state_in  = S_ROWZ;
            end
         end
         S_ROWZ: begin
            state_in = S_ROWZD;
         end
         S_ROWZD: begin
            zi_in    = zp_rdata;
            idx_in   = '0;
            state_in = S_ROWW;
         end
         S_ROWW: begin
            if (stream_done) begin
               idx_in   = '0;
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            if (stream_done) begin
               row_in = row_ff + 1'b1;
               idx_in = '0;
               if (row_ff + 1'b1 == n_ff) begin
                  state_in = S_DEN;
               end else begin
                  state_in = S_ROWZ;
               end
            end
         end
         S_DEN: begin
            if (stream_done) begin
               den_in = acc1[DEN_W-1:0];
               idx_in = '0;
               if ((sum_w_ff == '0) || (sum_z2_ff == '0)) begin
                  res_stat_in   = '0;
                  res_status_in = ST_ZERO_DEN;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_NUM;
               end
            end
         end
         S_NUM: begin
            if (stream_done) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if ((div_quo[NUM_W-1:32] != '0) || (div_quo[31:0] > limit)) begin
                  res_stat_in   = limit;
                  res_status_in = ST_SAT;
               end else begin
                  res_stat_in   = neg ? -div_quo[31:0] : div_quo[31:0];
                  res_status_in = ST_OK;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         obs_count_ff <= 7'(MAX_OBS);
         iss_ff       <= '0;
         zp_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         iss_ff    <= iss_in;
         zp_tag_ff <= zp_tag_in;
         if (csr_we) begin
            obs_count_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      row_ff        <= row_in;
      sum_y_ff      <= sum_y_in;
      sum_z2_ff     <= sum_z2_in;
      sum_w_ff      <= sum_w_in;
      zi_ff         <= zi_in;
      den_ff        <= den_in;
      res_stat_ff   <= res_stat_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_data_ff <= res_stat_ff;
         rsp_user_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_CLK(a_zero_den_value, rsp_tvalid && (rsp_tuser == ST_ZERO_DEN) |-> (rsp_tdata == '0))
   `ASSERT_CLK(a_sat_value, rsp_tvalid && (rsp_tuser == ST_SAT) |->
      (rsp_tdata == 32'h7FFF_FFFF) || (rsp_tdata == 32'h8000_0000))
   `ASSERT_CLK(a_div_start_idle, div_start |-> !div_busy)
   `ASSERT_NEXT(a_div_runs, div_start, div_busy)

endmodule

// ===== bench/moran_i_statistic_test.sv =====
// Self-checking bench for moran_i_statistic: loads observations and weights,
// requests the statistic and compares every result word against a predictor.
// Depends on mi_pkg and the moran_i_statistic RTL.
module moran_i_statistic_test;
   import mi_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         SETTLE     = 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [6:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int mismatches;
   int stats_seen;
   int words_sent;
   bit steady;

   moran_i_statistic dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Keeps a copy of both stores and the count, and the statistics still owed.
   class moran_scoreboard;
      logic signed [15:0] obs_mem [MAX_OBS];
      logic [15:0]        wgt_mem [MAX_OBS*MAX_OBS];
      logic [6:0]         count;
      logic [31:0]        stat_q [$];
      logic [1:0]         status_q [$];

      function void set_count(logic [6:0] v);
         count = v;
      endfunction

      function void compute_moran(output logic [31:0] stat, output logic [1:0] st);
         int n;
         longint sum_y, sum_w, sum_z2, row_sum;
         longint dev [MAX_OBS];
         logic signed [127:0] acc, term;
         logic [127:0] mag, den, top, q, limit;
         bit neg;
         n = (count > MAX_OBS) ? MAX_OBS : count;
         sum_y = 0; sum_w = 0; sum_z2 = 0; acc = 0;
         for (int i = 0; i < n; i++) sum_y += obs_mem[i];
         for (int i = 0; i < n; i++) begin
            dev[i] = longint'(n) * obs_mem[i] - sum_y;
            sum_z2 += dev[i] * dev[i];
         end
         for (int i = 0; i < n; i++) begin
            row_sum = 0;
            for (int j = 0; j < n; j++) begin
               sum_w += wgt_mem[i*MAX_OBS + j];
               row_sum += longint'(wgt_mem[i*MAX_OBS + j]) * dev[j];
            end
            term = dev[i];
            term = term * row_sum;
            acc += term;
         end
         if (sum_w == 0 || sum_z2 == 0) begin
            stat = 0;
            st = ST_ZERO_DEN;
            return;
         end
         neg = acc < 0;
         mag = neg ? -acc : acc;
         den = 128'(sum_w) * 128'(sum_z2);
         // Ties round away from zero: (2*a + d) / (2*d) on the magnitude.
         top = ((mag * n) << 17) + den;
         q = top / (den << 1);
         limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
         if (q > limit) begin
            stat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            st = ST_SAT;
         end else begin
            stat = neg ? -q[31:0] : q[31:0];
            st = ST_OK;
         end
      endfunction

      function void note_word(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                              logic signed [16:0] value);
         logic [31:0] stat;
         logic [1:0] st;
         case (cmd)
            CMD_LOAD_OBS: begin
               obs_mem[row] = (value > 32767) ? 16'sh7FFF :
                              (value < -32768) ? 16'sh8000 : value[15:0];
            end
            CMD_LOAD_WGT: begin
               wgt_mem[row*MAX_OBS + col] = (value < 0) ? 16'h0000 : value[15:0];
            end
            CMD_COMPUTE: begin
               compute_moran(stat, st);
               stat_q = {stat_q, stat};
               status_q = {status_q, st};
            end
            default: ;
         endcase
      endfunction

      // Returns 0 on a match; otherwise fills msg.
      function bit check_word(logic [31:0] stat, logic [1:0] st, output string msg);
         logic [31:0] es;
         logic [1:0] et;
         msg = "";
         if (stat_q.size() == 0) begin
            msg = $sformatf("unexpected result word %h status %0d", stat, st);
            return 1;
         end
         es = stat_q.pop_front();
         et = status_q.pop_front();
         if (stat !== es)
            msg = $sformatf("statistic %h, predicted %h", stat, es);
         if (st !== et)
            msg = {msg, $sformatf(" status %0d, predicted %0d", st, et)};
         return msg != "";
      endfunction

      function int owed();
         return stat_q.size();
      endfunction
   endclass

   moran_scoreboard sb;

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Result side: check each accepted word, then stall at random outside steady phases.
   always @(posedge clock) begin
      string msg;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            stats_seen++;
            if (sb.check_word(rsp_tdata, rsp_tuser, msg)) report(msg);
         end
         rsp_tready <= steady || ($urandom_range(99) >= 24);
      end
   end

   task automatic send_word(logic [1:0] cmd, int row, int col, logic signed [16:0] value);
      while (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, value, 6'(col), 6'(row)};
      do @(posedge clock); while (!req_tready);
      sb.note_word(cmd, 6'(row), 6'(col), value);
      words_sent++;
   endtask

   // Waits until no statistic is owed and the block has settled, then writes n.
   task automatic write_count(logic [6:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.owed() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_count(v);
   endtask

   function automatic logic signed [16:0] rand_obs();
      case ($urandom_range(3))
         0: return 17'($signed($urandom_range(131071)));
         1: return 17'($signed($urandom_range(511))) - 17'sd256;
         default: return 17'($signed($urandom_range(65535))) - 17'sd32768;
      endcase
   endfunction

   function automatic logic signed [16:0] rand_wgt();
      case ($urandom_range(7))
         0: return 17'sd0;
         1: return 17'($signed($urandom_range(131071)));
         2: return 17'($signed($urandom_range(65535)));
         default: return 17'($signed($urandom_range(512)));
      endcase
   endfunction

   task automatic fill_stores(int n);
      for (int i = 0; i < n; i++) send_word(CMD_LOAD_OBS, i, $urandom_range(63), rand_obs());
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) send_word(CMD_LOAD_WGT, i, j, rand_wgt());
   endtask

   initial begin
      int n;
      sb = new();
      sb.set_count(7'd64);
      mismatches = 0; stats_seen = 0; words_sent = 0;
      steady = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0; csr_wdata = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: saturating loads, ignored command, zero denominators, small counts.
      write_count(7'd2);
      send_word(CMD_LOAD_OBS, 0, 0, 17'sd65535);
      send_word(CMD_LOAD_OBS, 1, 63, -17'sd65536);
      send_word(CMD_LOAD_WGT, 0, 0, 17'sd0);
      send_word(CMD_LOAD_WGT, 0, 1, -17'sd5);
      send_word(CMD_LOAD_WGT, 1, 0, 17'sd65535);
      send_word(CMD_LOAD_WGT, 1, 1, -17'sd65536);
      send_word(CMD_COMPUTE, 0, 0, 17'sd0);
      send_word(CMD_UNUSED, 63, 63, -17'sd1);
      send_word(CMD_LOAD_WGT, 0, 1, 17'sd300);
      send_word(CMD_LOAD_WGT, 1, 1, 17'sd7);
      send_word(CMD_COMPUTE, 63, 63, -17'sd1);
      send_word(CMD_LOAD_WGT, 0, 1, 17'sd0);
      send_word(CMD_LOAD_WGT, 1, 0, 17'sd0);
      send_word(CMD_LOAD_WGT, 1, 1, 17'sd0);
      send_word(CMD_COMPUTE, 0, 0, 17'sd0);
      send_word(CMD_LOAD_WGT, 1, 0, 17'sd5);
      send_word(CMD_LOAD_OBS, 0, 0, 17'sd100);
      send_word(CMD_LOAD_OBS, 1, 0, 17'sd100);
      send_word(CMD_COMPUTE, 0, 0, 17'sd0);
      send_word(CMD_LOAD_OBS, 1, 0, -17'sd32768);
      write_count(7'd0);
      send_word(CMD_COMPUTE, 0, 0, 17'sd0);
      write_count(7'd1);
      send_word(CMD_COMPUTE, 0, 0, 17'sd0);

      // Random phases at small counts: refill, then mixed loads, computes and unused commands.
      for (int p = 0; p < 10; p++) begin
         n = (p == 9) ? $urandom_range(7, 8) : $urandom_range(2, 4);
         write_count(7'(n));
         steady = (p == 9);
         fill_stores(n);
         for (int k = 0; k < 20; k++) begin
            case ($urandom_range(9))
               0, 1: send_word(CMD_COMPUTE, $urandom_range(63), $urandom_range(63),
                               rand_obs());
               2: send_word(CMD_UNUSED, $urandom_range(63), $urandom_range(63),
                            rand_obs());
               3, 4, 5: send_word(CMD_LOAD_OBS, $urandom_range(n - 1),
                                  $urandom_range(63), rand_obs());
               default: send_word(CMD_LOAD_WGT, $urandom_range(n - 1),
                                  $urandom_range(n - 1), rand_wgt());
            endcase
         end
         send_word(CMD_COMPUTE, 0, 0, 17'sd0);
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.owed() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d words over counts 0 to 8; checked %0d statistics,", words_sent,
               stats_seen);
      $display("including clamped loads, zero denominators and the unused command.");
      if (mismatches == 0 && sb.owed() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out waiting for the block.");
      $display("Mismatches found");
      $finish;
   end

endmodule
